// ===== src/itoa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Longest field the block ever emits.
  localparam int MAX_WIDTH   = 64;
  // Digit buffer: 24 four-bit digit slots, enough for 22 octal digits.
  localparam int NUM_DIGITS  = 24;
  localparam int DIG_W       = 4;
  localparam int DIG_BUF_W   = NUM_DIGITS * DIG_W;
  localparam int NDIG_W      = $clog2(NUM_DIGITS + 1);
  // Binary-to-BCD conversion: 20 decimal digits, one shift per operand bit.
  localparam int BCD_DIGITS  = 20;
  localparam int BCD_W       = BCD_DIGITS * DIG_W;
  localparam int VALUE_W     = 64;
  localparam int ITER_W      = $clog2(VALUE_W);
  localparam int FW_W        = 7;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_LOWA  = 8'h61;
  localparam logic [7:0] CH_UPX   = 8'h58;
  localparam logic [7:0] CH_LOWX  = 8'h78;

  // Base select codes on the input beat.
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               signed_mode;
    logic [1:0]         base_sel;
    logic               uppercase;
    logic               left_align;
    logic               show_sign;
    logic               space_sign;
    logic               alternate;
    logic               zero_pad;
    logic [FW_W-1:0]    field_width;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_beat_t;

  // Request from the sequencer to the digit unit.
  typedef struct packed {
    logic   start;
    radix_t radix;
  } dig_req_t;

  // Completion status from the digit unit.
  typedef struct packed {
    logic              done;
    logic [NDIG_W-1:0] ndig;
  } dig_rsp_t;

  // Map one digit to its ASCII character.
  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upc);
    logic [7:0] d8;
    d8 = {4'b0, d};
    if (d < 4'd10) begin
      digit_char = CH_ZERO + d8;
    end else if (upc) begin
      digit_char = CH_UPA + d8 - 8'd10;
    end else begin
      digit_char = CH_LOWA + d8 - 8'd10;
    end
  endfunction

endpackage

// ===== src/itoa_digit_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_digit_unit
// Splits a 64-bit magnitude into digits of the selected radix. Decimal uses
// an iterative shift-and-add-3 unit (one operand bit per cycle); octal and
// hex load straight from the bits. A normalize pass then drops leading zero
// digits one per cycle and reports the digit count.
// ----------------------------------------------------------------------------
module itoa_digit_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  itoa_pkg::dig_req_t            req,
  input  logic [itoa_pkg::VALUE_W-1:0]  mag,
  output itoa_pkg::dig_rsp_t            rsp,
  output logic [itoa_pkg::DIG_BUF_W-1:0] digits
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DABBLE,
    S_NORM
  } state_t;

  localparam int TOP_LSB = itoa_pkg::DIG_BUF_W - itoa_pkg::DIG_W;

  state_t                          state_r, state_nxt;
  logic [itoa_pkg::DIG_BUF_W-1:0]  buf_r, buf_nxt;
  logic [itoa_pkg::VALUE_W-1:0]    bin_r, bin_nxt;
  logic [itoa_pkg::ITER_W-1:0]     iter_r, iter_nxt;
  logic [itoa_pkg::NDIG_W-1:0]     ndig_r, ndig_nxt;
  logic                            done_r, done_nxt;
  logic [itoa_pkg::BCD_W-1:0]      bcd_adj;
  logic [itoa_pkg::VALUE_W+1:0]    mag_ext;
  logic [itoa_pkg::DIG_BUF_W-1:0]  oct_buf;

  // Add 3 to every BCD digit of 5 or more before the shift.
  always_comb begin
    for (int j = 0; j < itoa_pkg::BCD_DIGITS; j++) begin
      if (buf_r[j*itoa_pkg::DIG_W +: itoa_pkg::DIG_W] >= 4'd5) begin
        bcd_adj[j*itoa_pkg::DIG_W +: itoa_pkg::DIG_W] =
          buf_r[j*itoa_pkg::DIG_W +: itoa_pkg::DIG_W] + 4'd3;
      end else begin
        bcd_adj[j*itoa_pkg::DIG_W +: itoa_pkg::DIG_W] =
          buf_r[j*itoa_pkg::DIG_W +: itoa_pkg::DIG_W];
      end
    end
  end

  // Spread 3-bit octal digits into 4-bit slots.
  always_comb begin
    mag_ext = {2'b00, mag};
    oct_buf = '0;
    for (int i = 0; i < (itoa_pkg::VALUE_W + 2) / 3; i++) begin
      oct_buf[i*itoa_pkg::DIG_W +: itoa_pkg::DIG_W] = {1'b0, mag_ext[i*3 +: 3]};
    end
  end

  // Sequencer: load, convert, normalize.
  always_comb begin
    state_nxt = state_r;
    buf_nxt   = buf_r;
    bin_nxt   = bin_r;
    iter_nxt  = iter_r;
    ndig_nxt  = ndig_r;
    done_nxt  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (req.start) begin
          ndig_nxt = itoa_pkg::NDIG_W'(itoa_pkg::NUM_DIGITS);
          case (req.radix)
            itoa_pkg::RADIX_DEC: begin
              buf_nxt   = '0;
              bin_nxt   = mag;
              iter_nxt  = '1;
              state_nxt = S_DABBLE;
            end
            itoa_pkg::RADIX_OCT: begin
              buf_nxt   = oct_buf;
              state_nxt = S_NORM;
            end
            default: begin
              buf_nxt   = {{(itoa_pkg::DIG_BUF_W - itoa_pkg::VALUE_W){1'b0}}, mag};
              state_nxt = S_NORM;
            end
          endcase
        end
      end
      S_DABBLE: begin
        buf_nxt = {{(itoa_pkg::DIG_BUF_W - itoa_pkg::BCD_W){1'b0}},
                   bcd_adj[itoa_pkg::BCD_W-2:0], bin_r[itoa_pkg::VALUE_W-1]};
        bin_nxt  = {bin_r[itoa_pkg::VALUE_W-2:0], 1'b0};
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if ((buf_r[TOP_LSB +: itoa_pkg::DIG_W] == '0) && (ndig_r > 1)) begin
          buf_nxt  = {buf_r[TOP_LSB-1:0], {itoa_pkg::DIG_W{1'b0}}};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    buf_r  <= buf_nxt;
    bin_r  <= bin_nxt;
    iter_r <= iter_nxt;
    ndig_r <= ndig_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.ndig = ndig_r;
  assign digits   = buf_r;

endmodule

// ===== src/integer_to_ascii_formatter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one 64-bit integer printf-style and streams its ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data take one beat per value: the operand and its
//   format flags. out_valid/out_ready/out_data return one beat per
//   character, with last set on the final character of the field.
//   A field is at most 64 characters.
// Timing:
//   in_ready is high only while idle; one value is worked on at a time.
//   Decimal runs through the shift-and-add-3 unit, octal and hex load
//   straight from the bits; leading zeros are then dropped at one digit a
//   cycle (up to 23 digits). Characters leave at one per cycle while
//   out_ready is high; a section with nothing to emit takes a state step.
// Reset:
//   rst_n (synchronous) returns to idle and drops out_valid.
// Stall:
//   out_ready low holds the current character in the output register and
//   the sequencer waits; no character is lost.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  itoa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output itoa_pkg::out_beat_t out_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CONVERT,
    S_PAD_LEAD,
    S_SIGN,
    S_PFX_ZERO,
    S_PFX_X,
    S_PAD_ZERO,
    S_DIGITS,
    S_PAD_TRAIL
  } state_t;

  localparam int TOP_LSB = itoa_pkg::DIG_BUF_W - itoa_pkg::DIG_W;
  localparam int CNT_W   = itoa_pkg::FW_W;

  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  itoa_pkg::out_beat_t             out_beat_r, out_beat_nxt;
  logic                            has_sign_r, has_sign_nxt;
  logic [7:0]                      sign_ch_r, sign_ch_nxt;
  logic [1:0]                      plen_r, plen_nxt;
  logic                            upc_r, upc_nxt;
  logic                            la_r, la_nxt;
  logic                            zp_r, zp_nxt;
  logic [itoa_pkg::FW_W-1:0]       fw_r, fw_nxt;
  logic [CNT_W-1:0]                pad_r, pad_nxt;
  logic [CNT_W-1:0]                remain_r, remain_nxt;
  logic [itoa_pkg::NDIG_W-1:0]     dcnt_r, dcnt_nxt;
  logic [itoa_pkg::DIG_BUF_W-1:0]  dig_r, dig_nxt;

  itoa_pkg::dig_req_t              req;
  itoa_pkg::dig_rsp_t              rsp;
  logic [itoa_pkg::DIG_BUF_W-1:0]  unit_digits;
  logic [itoa_pkg::VALUE_W-1:0]    mag;
  logic                            neg;
  logic                            accept;
  logic                            slot_free;
  logic                            emit;
  logic [7:0]                      emit_ch;
  logic [CNT_W-1:0]                content;
  logic [CNT_W-1:0]                total;

  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  // Magnitude and radix for the digit unit.
  always_comb begin
    neg = in_data.signed_mode && in_data.value[itoa_pkg::VALUE_W-1];
    mag = neg ? (~in_data.value + 1'b1) : in_data.value;
    req.start = accept;
    if (in_data.signed_mode || (in_data.base_sel == itoa_pkg::BASE_DEC)) begin
      req.radix = itoa_pkg::RADIX_DEC;
    end else if (in_data.base_sel == itoa_pkg::BASE_OCT) begin
      req.radix = itoa_pkg::RADIX_OCT;
    end else begin
      req.radix = itoa_pkg::RADIX_HEX;
    end
  end

  itoa_digit_unit u_digits (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .mag    (mag),
    .rsp    (rsp),
    .digits (unit_digits)
  );

  // Field length: sign + prefix + digits, padded up to the width.
  always_comb begin
    content = CNT_W'(has_sign_r) + CNT_W'(plen_r) + CNT_W'(rsp.ndig);
    total   = (fw_r > content) ? fw_r : content;
  end

  // Sequencer: walk the field sections in print order.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_beat_nxt  = out_beat_r;
    has_sign_nxt  = has_sign_r;
    sign_ch_nxt   = sign_ch_r;
    plen_nxt      = plen_r;
    upc_nxt       = upc_r;
    la_nxt        = la_r;
    zp_nxt        = zp_r;
    fw_nxt        = fw_r;
    pad_nxt       = pad_r;
    remain_nxt    = remain_r;
    dcnt_nxt      = dcnt_r;
    dig_nxt       = dig_r;
    emit          = 1'b0;
    emit_ch       = itoa_pkg::CH_SPACE;

    // Drop the output beat once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          has_sign_nxt = neg || (in_data.signed_mode &&
                                 (in_data.show_sign || in_data.space_sign));
          if (neg) begin
            sign_ch_nxt = itoa_pkg::CH_MINUS;
          end else if (in_data.show_sign) begin
            sign_ch_nxt = itoa_pkg::CH_PLUS;
          end else begin
            sign_ch_nxt = itoa_pkg::CH_SPACE;
          end
          plen_nxt = 2'd0;
          if (in_data.alternate && !in_data.signed_mode && (in_data.value != '0)) begin
            if (in_data.base_sel == itoa_pkg::BASE_OCT) begin
              plen_nxt = 2'd1;
            end else if (in_data.base_sel != itoa_pkg::BASE_DEC) begin
              plen_nxt = 2'd2;
            end
          end
          upc_nxt = in_data.uppercase && !in_data.signed_mode;
          la_nxt  = in_data.left_align;
          zp_nxt  = in_data.zero_pad;
          if (in_data.field_width > itoa_pkg::FW_W'(itoa_pkg::MAX_WIDTH)) begin
            fw_nxt = itoa_pkg::FW_W'(itoa_pkg::MAX_WIDTH);
          end else begin
            fw_nxt = in_data.field_width;
          end
          state_nxt = S_CONVERT;
        end
      end
      S_CONVERT: begin
        if (rsp.done) begin
          dig_nxt    = unit_digits;
          dcnt_nxt   = rsp.ndig;
          pad_nxt    = total - content;
          remain_nxt = total;
          state_nxt  = S_PAD_LEAD;
        end
      end
      S_PAD_LEAD: begin
        if (la_r || zp_r || (pad_r == '0)) begin
          state_nxt = S_SIGN;
        end else if (slot_free) begin
          emit    = 1'b1;
          emit_ch = itoa_pkg::CH_SPACE;
          pad_nxt = pad_r - 1'b1;
          if (pad_r == CNT_W'(1)) begin
            state_nxt = S_SIGN;
          end
        end
      end
      S_SIGN: begin
        if (!has_sign_r) begin
          state_nxt = S_PFX_ZERO;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_ch   = sign_ch_r;
          state_nxt = S_PFX_ZERO;
        end
      end
      S_PFX_ZERO: begin
        if (plen_r == 2'd0) begin
          state_nxt = S_PAD_ZERO;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_ch   = itoa_pkg::CH_ZERO;
          state_nxt = (plen_r == 2'd2) ? S_PFX_X : S_PAD_ZERO;
        end
      end
      S_PFX_X: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_ch   = upc_r ? itoa_pkg::CH_UPX : itoa_pkg::CH_LOWX;
          state_nxt = S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        if (la_r || !zp_r || (pad_r == '0)) begin
          state_nxt = S_DIGITS;
        end else if (slot_free) begin
          emit    = 1'b1;
          emit_ch = itoa_pkg::CH_ZERO;
          pad_nxt = pad_r - 1'b1;
          if (pad_r == CNT_W'(1)) begin
            state_nxt = S_DIGITS;
          end
        end
      end
      S_DIGITS: begin
        if (dcnt_r == '0) begin
          state_nxt = S_PAD_TRAIL;
        end else if (slot_free) begin
          emit     = 1'b1;
          emit_ch  = itoa_pkg::digit_char(dig_r[TOP_LSB +: itoa_pkg::DIG_W], upc_r);
          dig_nxt  = {dig_r[TOP_LSB-1:0], {itoa_pkg::DIG_W{1'b0}}};
          dcnt_nxt = dcnt_r - 1'b1;
          if (dcnt_r == itoa_pkg::NDIG_W'(1)) begin
            state_nxt = S_PAD_TRAIL;
          end
        end
      end
      S_PAD_TRAIL: begin
        if (!la_r || (pad_r == '0)) begin
          state_nxt = S_IDLE;
        end else if (slot_free) begin
          emit    = 1'b1;
          emit_ch = itoa_pkg::CH_SPACE;
          pad_nxt = pad_r - 1'b1;
          if (pad_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Load the output register with the emitted character.
    if (emit) begin
      out_valid_nxt         = 1'b1;
      out_beat_nxt.out_char = emit_ch;
      out_beat_nxt.last     = (remain_r == CNT_W'(1));
      remain_nxt            = remain_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_beat_r <= out_beat_nxt;
    has_sign_r <= has_sign_nxt;
    sign_ch_r  <= sign_ch_nxt;
    plen_r     <= plen_nxt;
    upc_r      <= upc_nxt;
    la_r       <= la_nxt;
    zp_r       <= zp_nxt;
    fw_r       <= fw_nxt;
    pad_r      <= pad_nxt;
    remain_r   <= remain_nxt;
    dcnt_r     <= dcnt_nxt;
    dig_r      <= dig_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule
